FILE: design/sls_pkg.sv
package sls_pkg;

    localparam int CAPACITY  = 32;
    localparam int WORD_BITS = 32;

    // field widths of the stream payload
    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = 5;
    localparam int COUNT_BITS = 6;
    localparam int ACT_BITS   = 2;

    localparam int S_DATA_W = ((VALUE_BITS + POS_BITS + 7) / 8) * 8;
    localparam int M_RAW_W  = 1 + VALUE_BITS + COUNT_BITS + 1 + 1;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_READ_DATA,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        t_addr raddr;
    } t_ram_req;

    typedef struct packed {
        logic                  ok;
        logic [VALUE_BITS-1:0] rdata;
        t_cnt                  count;
    } t_result;

endpackage

FILE: design/sls_ram.sv
module sls_ram (
    input  logic              i_clk,
    input  sls_pkg::t_ram_req i_req,
    output sls_pkg::t_word    o_rd_data
);
    import sls_pkg::*;

    t_word r_mem [CAPACITY];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/sls_ctrl.sv
module sls_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  sls_pkg::t_action                 i_action,
    input  logic [sls_pkg::VALUE_BITS-1:0]   i_value,
    input  logic [sls_pkg::POS_BITS-1:0]     i_position,
    output sls_pkg::t_ram_req                o_ram,
    input  sls_pkg::t_word                   i_rd_data,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output sls_pkg::t_result                 o_res
);
    import sls_pkg::*;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_cnt   r_idx,   n_idx;
    logic   r_chk,   n_chk;
    logic   r_ok,    n_ok;
    t_word  r_value, n_value;
    logic [VALUE_BITS-1:0] r_rdata, n_rdata;

    logic  in_fire;
    logic  in_range;
    logic  hit;
    logic  idx_lt_cnt;
    t_cnt  idx_m2;

    assign in_fire    = i_valid && o_ready;
    assign in_range   = 32'(i_position) < 32'(r_count);
    assign hit        = (i_rd_data == r_value);
    assign idx_lt_cnt = (r_idx < r_count);
    assign idx_m2     = r_idx - CNT_W'(2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_action)
                        ACT_APPEND: n_state = S_DONE;
                        ACT_CLEAR:  n_state = S_DONE;
                        ACT_REMOVE: n_state = S_SEARCH;
                        ACT_READ:   n_state = in_range ? S_READ : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_READ:      n_state = S_READ_DATA;
            S_READ_DATA: n_state = S_DONE;
            S_SEARCH: begin
                if (r_chk && hit) begin
                    n_state = S_SHIFT;
                end else if (!idx_lt_cnt) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (!r_chk) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        n_chk   = r_chk;
        n_ok    = r_ok;
        n_value = r_value;
        n_rdata = r_rdata;

        o_ram.we    = 1'b0;
        o_ram.waddr = r_count[ADDR_W-1:0];
        o_ram.wdata = WORD_BITS'(i_value);
        // the read port always follows the scan index
        o_ram.raddr = r_idx[ADDR_W-1:0];

        o_ready     = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_value = WORD_BITS'(i_value);
                    n_idx   = '0;
                    n_chk   = 1'b0;
                    n_ok    = 1'b0;
                    n_rdata = '0;
                    unique case (i_action)
                        ACT_APPEND: begin
                            if (32'(r_count) < CAPACITY) begin
                                o_ram.we = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_ok     = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_ok    = 1'b1;
                        end
                        ACT_READ: begin
                            if (in_range) begin
                                n_idx = CNT_W'(i_position);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: ;
            S_READ_DATA: begin
                n_ok    = 1'b1;
                n_rdata = VALUE_BITS'(i_rd_data);
            end
            S_SEARCH: begin
                // read data holds the entry below the scan index when r_chk is set
                if ((r_chk && hit) || idx_lt_cnt) begin
                    n_idx = r_idx + 1'b1;
                    n_chk = idx_lt_cnt;
                end
            end
            S_SHIFT: begin
                if (r_chk) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = idx_m2[ADDR_W-1:0];
                    o_ram.wdata = i_rd_data;
                    n_idx       = r_idx + 1'b1;
                    n_chk       = idx_lt_cnt;
                end else begin
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_value <= n_value;
        r_rdata <= n_rdata;
    end

    assign o_res.ok    = r_ok;
    assign o_res.rdata = r_rdata;
    assign o_res.count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("entry count above capacity");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_state == S_IDLE || r_state == S_SHIFT))
        else $error("memory write outside append or shift");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_action == ACT_APPEND && 32'(r_count) < CAPACITY)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not advance count");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_idx <= r_count))
        else $error("search index beyond count");

    a_shift_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_chk) |-> (r_idx >= CNT_W'(2)))
        else $error("shift write below list start");

endmodule

FILE: design/sequential_list_store.sv
// Append, clear, out-of-range read: the accept goes straight to S_DONE, whose result loads the output register.
// Read in range: S_READ and S_READ_DATA come before S_DONE, set by the registered memory read port.
// Remove: S_SEARCH scans for the value and, when found, S_SHIFT moves the entries above it down one place;
// one memory read per cycle drives the search, then the shift, over at most the whole list.
// One transaction at a time: s_tready returns once the result has moved to the output register.
// Synchronous active-low reset empties the list; the stored words stay undefined until written.
module sequential_list_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // value [31:0], position [36:32], zero pad above
    input  logic [sls_pkg::S_DATA_W-1:0]   i_s_tdata,
    // action [1:0]
    input  logic [sls_pkg::ACT_BITS-1:0]   i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // ok [0], read_value [32:1], count [38:33], is_empty [39], is_full [40], zero pad above
    output logic [sls_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import sls_pkg::*;

    t_ram_req ram_req;
    t_word    rd_data;
    logic     res_valid;
    logic     res_ready;
    t_result  res;

    logic                  r_m_valid;
    logic [M_DATA_W-1:0]   r_m_data;
    logic [M_DATA_W-1:0]   n_m_data;
    logic                  res_empty;
    logic                  res_full;

    sls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_action    (t_action'(i_s_tuser)),
        .i_value     (i_s_tdata[VALUE_BITS-1:0]),
        .i_position  (i_s_tdata[VALUE_BITS +: POS_BITS]),
        .o_ram       (ram_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    sls_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign res_ready = !r_m_valid || i_m_tready;
    assign res_empty = (res.count == '0);
    assign res_full  = (32'(res.count) == CAPACITY);

    always_comb begin
        n_m_data = '0;
        n_m_data[M_RAW_W-1:0] = {res_full, res_empty, COUNT_BITS'(res.count),
                                 res.rdata, res.ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    // hold the payload while the transaction is stalled
    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule
